// ----- rtl/swhm_pkg.sv -----
`default_nettype none
package swhm_pkg;

  // ring depth default
  localparam int SPIKE_DEPTH_DEF = 32;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int TIME_W   = 32;
  localparam int RMS_W    = 16;
  localparam int COUNT_W  = 32;
  localparam int RECENT_W = 6;
  localparam int SCORE_W  = 10;
  localparam int LEVEL_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PEN_W    = 13;
  localparam int PROD_W   = 21;

  // request function codes
  localparam logic [FUNC_W-1:0] FUNC_RECORD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OK     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN   = 2'd2;

  // config reset values
  localparam logic [TIME_W-1:0]  WINDOW_RST = 32'd10000;
  localparam logic [SCORE_W-1:0] OK_RST     = 10'd820;
  localparam logic [SCORE_W-1:0] WARN_RST   = 10'd620;

  // health level codes
  localparam logic [LEVEL_W-1:0] LVL_OK       = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_WARN     = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_DEGRADED = 2'd2;

  // score and penalty weights
  localparam logic [SCORE_W-1:0] SCORE_INIT = 10'd1000;
  localparam int GYRO_W   = 25;
  localparam int CURSOR_W = 18;
  localparam int NAN_W    = 20;
  localparam int NAN_CAP  = 400;
  localparam int REC_W    = 35;
  localparam int REC_CAP  = 300;
  localparam int SPK_W    = 12;
  localparam int SPK_CAP  = 300;
  localparam int FAIL_W   = 18;
  localparam int FAIL_CAP = 400;
  localparam int NAN_LIM  = NAN_CAP / NAN_W;
  localparam int REC_LIM  = REC_CAP / REC_W;
  localparam int SPK_LIM  = SPK_CAP / SPK_W;
  localparam int FAIL_LIM = FAIL_CAP / FAIL_W;

  // penalty step select
  localparam int PSEL_W = 3;
  localparam logic [PSEL_W-1:0] PEN_GYRO   = 3'd0;
  localparam logic [PSEL_W-1:0] PEN_CURSOR = 3'd1;
  localparam logic [PSEL_W-1:0] PEN_NAN    = 3'd2;
  localparam logic [PSEL_W-1:0] PEN_REC    = 3'd3;
  localparam logic [PSEL_W-1:0] PEN_SPIKE  = 3'd4;
  localparam logic [PSEL_W-1:0] PEN_FAIL   = 3'd5;

  typedef struct packed {
    logic              record;
    logic              clear;
    logic              start;
    logic              walk;
    logic              pen;
    logic [PSEL_W-1:0] pen_sel;
    logic              out_load;
  } swhm_cmd_t;

  typedef struct packed {
    logic walk_done;
  } swhm_stat_t;

endpackage
`default_nettype wire

// ----- rtl/swhm_ram.sv -----
`default_nettype none
module swhm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/swhm_ctrl.sv -----
`default_nettype none
module swhm_ctrl
  import swhm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [FUNC_W-1:0] in_func,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire swhm_stat_t        stat,
  output swhm_cmd_t              cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_PEN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [PSEL_W-1:0] pen_cnt_r, pen_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    pen_cnt_nxt   = pen_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.pen_sel   = pen_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.record = accept && (in_func == FUNC_RECORD);
        cmd.clear  = accept && (in_func == FUNC_CLEAR);
        cmd.start  = accept && (in_func == FUNC_QUERY);
        if (cmd.start) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          state_nxt   = ST_PEN;
          pen_cnt_nxt = PEN_GYRO;
        end
      end
      ST_PEN: begin
        cmd.pen     = 1'b1;
        pen_cnt_nxt = pen_cnt_r + 1'b1;
        if (pen_cnt_r == PEN_FAIL) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pen_cnt_r   <= PEN_GYRO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pen_cnt_r   <= pen_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a walk only starts from an accepted query
  a_walk_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && $past(state_r) != ST_WALK)
      |-> $past(in_valid && in_func == FUNC_QUERY))
    else $error("walk entered without a query");

  // loading the result raises out_valid
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result loaded but not shown");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- rtl/swhm_dp.sv -----
`default_nettype none
module swhm_dp
  import swhm_pkg::*;
#(
  parameter int SPIKE_DEPTH = SPIKE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire swhm_cmd_t             cmd,
  output swhm_stat_t                 stat,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [TIME_W-1:0]     in_now_ms,
  input  wire logic [RMS_W-1:0]      in_gyro_rms_q8,
  input  wire logic [RMS_W-1:0]      in_cursor_rms_q8,
  input  wire logic [COUNT_W-1:0]    in_nan_error_count,
  input  wire logic [COUNT_W-1:0]    in_recover_count,
  input  wire logic [COUNT_W-1:0]    in_fail_run,
  output logic      [RECENT_W-1:0]   out_recent_spikes,
  output logic      [SCORE_W-1:0]    out_score,
  output logic      [LEVEL_W-1:0]    out_health_level
);

  localparam int AW = $clog2(SPIKE_DEPTH);
  localparam int CW = $clog2(SPIKE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SPIKE_DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(SPIKE_DEPTH);

  // config
  logic [TIME_W-1:0]  window_r;
  logic [SCORE_W-1:0] ok_lvl_r, warn_lvl_r;

  // ring control
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;

  // query operands
  logic [TIME_W-1:0]  now_r;
  logic [RMS_W-1:0]   gyro_r, cursor_r;
  logic [COUNT_W-1:0] nan_r, rec_r, fail_r;

  // walk state
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic          stop_r, stop_nxt;
  logic [TIME_W-1:0] rdata, age;
  logic          cmp_en, fail_now, issue_en;

  // score
  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [PROD_W-1:0]  gyro_prod, cursor_prod;
  logic [PEN_W-1:0]   pen;
  logic [LEVEL_W-1:0] level;

  // output payload
  logic [RECENT_W-1:0] recent_r;
  logic [SCORE_W-1:0]  score_out_r;
  logic [LEVEL_W-1:0]  level_r;

  swhm_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SPIKE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.record),
    .waddr (head_r),
    .wdata (in_now_ms),
    .raddr (rd_ptr_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= WINDOW_RST;
      ok_lvl_r   <= OK_RST;
      warn_lvl_r <= WARN_RST;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_WINDOW) begin
        window_r <= cfg_wdata;
      end
      if (cfg_idx == CFG_OK) begin
        ok_lvl_r <= cfg_wdata[SCORE_W-1:0];
      end
      if (cfg_idx == CFG_WARN) begin
        warn_lvl_r <= cfg_wdata[SCORE_W-1:0];
      end
    end
  end

  // ring head and fill
  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (cmd.clear) begin
      head_nxt = '0;
      fill_nxt = '0;
    end else if (cmd.record) begin
      head_nxt = (head_r == LAST_ADDR) ? '0 : head_r + 1'b1;
      if (fill_r != FULL) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  // walk newest to oldest, one read issued per cycle, compared in the cycle after
  assign age      = now_r - rdata;
  assign cmp_en   = pend_r && !stop_r;
  assign fail_now = cmp_en && (age > window_r);
  assign issue_en = !stop_r && !fail_now && (iss_r != fill_r);
  assign stat.walk_done = !pend_r && (stop_r || (iss_r == fill_r));

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    iss_nxt    = iss_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    stop_nxt   = stop_r;
    if (cmd.start) begin
      rd_ptr_nxt = (head_r == '0) ? LAST_ADDR : head_r - 1'b1;
      iss_nxt    = '0;
      cnt_nxt    = '0;
      pend_nxt   = 1'b0;
      stop_nxt   = 1'b0;
    end else if (cmd.walk) begin
      if (cmp_en && !fail_now) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (fail_now) begin
        stop_nxt = 1'b1;
      end
      pend_nxt = issue_en;
      if (issue_en) begin
        iss_nxt    = iss_r + 1'b1;
        rd_ptr_nxt = (rd_ptr_r == '0) ? LAST_ADDR : rd_ptr_r - 1'b1;
      end
    end
  end

  // penalty for the current step
  assign gyro_prod   = PROD_W'(gyro_r) * PROD_W'(GYRO_W);
  assign cursor_prod = PROD_W'(cursor_r) * PROD_W'(CURSOR_W);

  always_comb begin
    unique case (cmd.pen_sel)
      PEN_GYRO:   pen = gyro_prod[PROD_W-1:8];
      PEN_CURSOR: pen = cursor_prod[PROD_W-1:8];
      PEN_NAN:    pen = (nan_r > COUNT_W'(NAN_LIM)) ? PEN_W'(NAN_CAP)
                                                   : PEN_W'(nan_r) * PEN_W'(NAN_W);
      PEN_REC:    pen = (rec_r > COUNT_W'(REC_LIM)) ? PEN_W'(REC_CAP)
                                                   : PEN_W'(rec_r) * PEN_W'(REC_W);
      PEN_SPIKE:  pen = (PEN_W'(cnt_r) > PEN_W'(SPK_LIM)) ? PEN_W'(SPK_CAP)
                                                         : PEN_W'(cnt_r) * PEN_W'(SPK_W);
      PEN_FAIL:   pen = (fail_r > COUNT_W'(FAIL_LIM)) ? PEN_W'(FAIL_CAP)
                                                     : PEN_W'(fail_r) * PEN_W'(FAIL_W);
      default:    pen = '0;
    endcase
  end

  always_comb begin
    score_nxt = score_r;
    if (cmd.start) begin
      score_nxt = SCORE_INIT;
    end else if (cmd.pen) begin
      // floored at zero
      if (pen >= PEN_W'(score_r)) begin
        score_nxt = '0;
      end else begin
        score_nxt = score_r - pen[SCORE_W-1:0];
      end
    end
  end

  // ok test first, then warn
  always_comb begin
    if (score_r >= ok_lvl_r) begin
      level = LVL_OK;
    end else if (score_r >= warn_lvl_r) begin
      level = LVL_WARN;
    end else begin
      level = LVL_DEGRADED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      fill_r   <= '0;
      rd_ptr_r <= '0;
      iss_r    <= '0;
      cnt_r    <= '0;
      pend_r   <= 1'b0;
      stop_r   <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      iss_r    <= iss_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      stop_r   <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    if (cmd.start) begin
      now_r    <= in_now_ms;
      gyro_r   <= in_gyro_rms_q8;
      cursor_r <= in_cursor_rms_q8;
      nan_r    <= in_nan_error_count;
      rec_r    <= in_recover_count;
      fail_r   <= in_fail_run;
    end
    if (cmd.out_load) begin
      recent_r    <= RECENT_W'(cnt_r);
      score_out_r <= score_r;
      level_r     <= level;
    end
  end

  assign out_recent_spikes = recent_r;
  assign out_score         = score_out_r;
  assign out_health_level  = level_r;

  // during a walk, matched entries never outrun issued reads, reads never outrun fill
  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> ((cnt_r <= iss_r) && (iss_r <= fill_r)))
    else $error("walk counters out of bounds");

endmodule
`default_nettype wire

// ----- rtl/spike_window_health_monitor.sv -----
`default_nettype none
// spike window health monitor
//
// input channel (in_valid / in_ready): one request per handshake, in_func
// selects record (store in_now_ms as newest spike), query or clear ring.
// record, clear and the unused code give no result; in_ready stays high.
// a query walks the spike ring from the newest entry, one ring read per
// cycle, then runs six penalty steps, one per cycle, and loads one result.
// the walk reads at most fill entries and stops early at an entry older
// than the window; the ring read port is registered.
// in_ready is high only while the controller is idle, so a query blocks
// the next request until its result is loaded.
// result channel (out_valid / out_ready): the result sits in an output
// register, so requests are taken while it waits; a finished query holds
// until the register is free when the receiver stalls.
// config port: cfg_we writes cfg_wdata into register cfg_idx (0 window ms,
// 1 ok level, 2 warn level); the user writes only while idle, unenforced.
// reset (rst_n low, synchronous): config to defaults, ring empty, no result
// pending; ring storage itself is not cleared, the fill count guards it.
module spike_window_health_monitor
  import swhm_pkg::*;
#(
  parameter int SPIKE_DEPTH = SPIKE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // config write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FUNC_W-1:0]     in_func,
  input  wire logic [TIME_W-1:0]     in_now_ms,
  input  wire logic [RMS_W-1:0]      in_gyro_rms_q8,
  input  wire logic [RMS_W-1:0]      in_cursor_rms_q8,
  input  wire logic [COUNT_W-1:0]    in_nan_error_count,
  input  wire logic [COUNT_W-1:0]    in_recover_count,
  input  wire logic [COUNT_W-1:0]    in_fail_run,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [RECENT_W-1:0]   out_recent_spikes,
  output logic      [SCORE_W-1:0]    out_score,
  output logic      [LEVEL_W-1:0]    out_health_level
);

  swhm_cmd_t  cmd;
  swhm_stat_t stat;

  // sequencing: idle, ring walk, penalty steps, result load
  swhm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // ring, config registers, score arithmetic and result register
  swhm_dp #(
    .SPIKE_DEPTH (SPIKE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata),
    .in_now_ms          (in_now_ms),
    .in_gyro_rms_q8     (in_gyro_rms_q8),
    .in_cursor_rms_q8   (in_cursor_rms_q8),
    .in_nan_error_count (in_nan_error_count),
    .in_recover_count   (in_recover_count),
    .in_fail_run        (in_fail_run),
    .out_recent_spikes  (out_recent_spikes),
    .out_score          (out_score),
    .out_health_level   (out_health_level)
  );

endmodule
`default_nettype wire

// ----- tb/health_score_checker.sv -----
`timescale 1ns / 100ps
module swhm_checker
  import swhm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic [RMS_W-1:0]      in_gyro_rms_q8,
  input  logic [RMS_W-1:0]      in_cursor_rms_q8,
  input  logic [COUNT_W-1:0]    in_nan_error_count,
  input  logic [COUNT_W-1:0]    in_recover_count,
  input  logic [COUNT_W-1:0]    in_fail_run,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [RECENT_W-1:0]   out_recent_spikes,
  input  logic [SCORE_W-1:0]    out_score,
  input  logic [LEVEL_W-1:0]    out_health_level,
  output int                    mismatches,
  output int                    open_queries
);

  localparam int RING_SLOTS = SPIKE_DEPTH_DEF;
  localparam int SLOT_W     = $clog2(RING_SLOTS);

  localparam longint unsigned SCORE_FULL    = 1000;
  localparam longint unsigned GYRO_WEIGHT   = 25;
  localparam longint unsigned CURSOR_WEIGHT = 18;
  localparam longint unsigned NAN_WEIGHT    = 20;
  localparam longint unsigned NAN_LIMIT     = 400;
  localparam longint unsigned REC_WEIGHT    = 35;
  localparam longint unsigned REC_LIMIT     = 300;
  localparam longint unsigned SPIKE_WEIGHT  = 12;
  localparam longint unsigned SPIKE_LIMIT   = 300;
  localparam longint unsigned FAIL_WEIGHT   = 18;
  localparam longint unsigned FAIL_LIMIT    = 400;

  typedef struct packed {
    logic [RECENT_W-1:0] recent;
    logic [SCORE_W-1:0]  score;
    logic [LEVEL_W-1:0]  level;
  } health_t;

  health_t           health_due[$];
  logic [TIME_W-1:0] spike_ts [RING_SLOTS];
  logic [SLOT_W-1:0] ring_head;
  int                ring_fill;
  logic [TIME_W-1:0] window_ms;
  logic [SCORE_W-1:0] ok_lvl;
  logic [SCORE_W-1:0] warn_lvl;
  int                fail_tally = 0;

  // newest first, stop at the first spike outside the window
  function automatic int recent_count(logic [TIME_W-1:0] now);
    int                n;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] age;
    n = 0;
    for (int i = 0; i < ring_fill; i++) begin
      slot = ring_head - SLOT_W'(i + 1);
      age  = now - spike_ts[slot];
      if (age > window_ms) break;
      n++;
    end
    return n;
  endfunction

  function automatic longint unsigned capped(longint unsigned count,
                                             longint unsigned weight,
                                             longint unsigned limit);
    longint unsigned p;
    p = count * weight;
    return (p > limit) ? limit : p;
  endfunction

  function automatic longint unsigned deduct(longint unsigned s, longint unsigned p);
    return (p >= s) ? 64'd0 : s - p;
  endfunction

  function automatic health_t predict_health(logic [TIME_W-1:0]  now,
                                             logic [RMS_W-1:0]   gyro,
                                             logic [RMS_W-1:0]   cursor,
                                             logic [COUNT_W-1:0] nan_cnt,
                                             logic [COUNT_W-1:0] rec_cnt,
                                             logic [COUNT_W-1:0] fails);
    health_t         h;
    int              n;
    longint unsigned s;
    n = recent_count(now);
    s = SCORE_FULL;
    s = deduct(s, (64'(gyro) * GYRO_WEIGHT) >> 8);
    s = deduct(s, (64'(cursor) * CURSOR_WEIGHT) >> 8);
    s = deduct(s, capped(64'(nan_cnt), NAN_WEIGHT, NAN_LIMIT));
    s = deduct(s, capped(64'(rec_cnt), REC_WEIGHT, REC_LIMIT));
    s = deduct(s, capped(64'(n), SPIKE_WEIGHT, SPIKE_LIMIT));
    s = deduct(s, capped(64'(fails), FAIL_WEIGHT, FAIL_LIMIT));
    h.recent = RECENT_W'(n);
    h.score  = SCORE_W'(s);
    if (s >= ok_lvl) h.level = LVL_OK;
    else if (s >= warn_lvl) h.level = LVL_WARN;
    else h.level = LVL_DEGRADED;
    return h;
  endfunction

  always @(posedge clk) begin : watch
    health_t want;
    if (!rst_n) begin
      health_due.delete();
      for (int i = 0; i < RING_SLOTS; i++) spike_ts[i] = '0;
      ring_head = '0;
      ring_fill = 0;
      window_ms = WINDOW_RST;
      ok_lvl    = OK_RST;
      warn_lvl  = WARN_RST;
    end else begin
      // results first: one leaving now was predicted at an earlier edge
      if (out_valid && out_ready) begin
        if (health_due.size() == 0) begin
          $display("%0t: unexpected result, recent %0d score %0d level %0d", $time,
                   out_recent_spikes, out_score, out_health_level);
          fail_tally++;
        end else begin
          want = health_due.pop_front();
          if (out_recent_spikes !== want.recent) begin
            $display("%0t: recent_spikes expected %0d, got %0d", $time,
                     want.recent, out_recent_spikes);
            fail_tally++;
          end
          if (out_score !== want.score) begin
            $display("%0t: score expected %0d, got %0d", $time,
                     want.score, out_score);
            fail_tally++;
          end
          if (out_health_level !== want.level) begin
            $display("%0t: health_level expected %0d, got %0d", $time,
                     want.level, out_health_level);
            fail_tally++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_WINDOW: window_ms = cfg_wdata;
          CFG_OK:     ok_lvl    = cfg_wdata[SCORE_W-1:0];
          CFG_WARN:   warn_lvl  = cfg_wdata[SCORE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_func)
          FUNC_RECORD: begin
            spike_ts[ring_head] = in_now_ms;
            ring_head = ring_head + 1'b1;
            if (ring_fill < RING_SLOTS) ring_fill++;
          end
          FUNC_QUERY:
            health_due.push_back(predict_health(in_now_ms, in_gyro_rms_q8,
                                                in_cursor_rms_q8, in_nan_error_count,
                                                in_recover_count, in_fail_run));
          FUNC_CLEAR: begin
            for (int i = 0; i < RING_SLOTS; i++) spike_ts[i] = '0;
            ring_head = '0;
            ring_fill = 0;
          end
          default: ;
        endcase
      end
    end
    open_queries <= health_due.size();
    mismatches   <= fail_tally;
  end

endmodule

// ----- tb/tb_spike_window_health_monitor.sv -----
`timescale 1ns / 100ps
module tb_spike_window_health_monitor;
  import swhm_pkg::*;

  // codes the package leaves unnamed
  localparam logic [FUNC_W-1:0]    FUNC_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 320;
  // longest query: full ring walk plus penalty steps, with margin
  localparam int QUIET_CYCLES = 48;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func = FUNC_RECORD;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic [RMS_W-1:0]      in_gyro_rms_q8 = '0;
  logic [RMS_W-1:0]      in_cursor_rms_q8 = '0;
  logic [COUNT_W-1:0]    in_nan_error_count = '0;
  logic [COUNT_W-1:0]    in_recover_count = '0;
  logic [COUNT_W-1:0]    in_fail_run = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [RECENT_W-1:0]   out_recent_spikes;
  logic [SCORE_W-1:0]    out_score;
  logic [LEVEL_W-1:0]    out_health_level;

  int mismatches;
  int open_queries;

  // idling switches, turned off in the quiet stretches and at the end
  bit sender_idle = 1'b0;
  bit sink_stalls = 1'b0;

  // timeline of the spike stream
  logic [TIME_W-1:0] t_now = '0;
  logic [TIME_W-1:0] last_rec = '0;
  logic [TIME_W-1:0] win_cur = WINDOW_RST;

  spike_window_health_monitor dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_now_ms          (in_now_ms),
    .in_gyro_rms_q8     (in_gyro_rms_q8),
    .in_cursor_rms_q8   (in_cursor_rms_q8),
    .in_nan_error_count (in_nan_error_count),
    .in_recover_count   (in_recover_count),
    .in_fail_run        (in_fail_run),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_recent_spikes  (out_recent_spikes),
    .out_score          (out_score),
    .out_health_level   (out_health_level)
  );

  // predicts every query and compares the results as they leave
  swhm_checker health_watch (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_now_ms          (in_now_ms),
    .in_gyro_rms_q8     (in_gyro_rms_q8),
    .in_cursor_rms_q8   (in_cursor_rms_q8),
    .in_nan_error_count (in_nan_error_count),
    .in_recover_count   (in_recover_count),
    .in_fail_run        (in_fail_run),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_recent_spikes  (out_recent_spikes),
    .out_score          (out_score),
    .out_health_level   (out_health_level),
    .mismatches         (mismatches),
    .open_queries       (open_queries)
  );

  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #(10_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stall bursts while enabled
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // entered and left at a rising edge; the request is taken at the last edge
  task automatic offer(logic [FUNC_W-1:0] func, logic [TIME_W-1:0] now,
                       logic [RMS_W-1:0] gyro, logic [RMS_W-1:0] cursor,
                       logic [COUNT_W-1:0] nan_cnt, logic [COUNT_W-1:0] rec_cnt,
                       logic [COUNT_W-1:0] fails);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_func            <= func;
    in_now_ms          <= now;
    in_gyro_rms_q8     <= gyro;
    in_cursor_rms_q8   <= cursor;
    in_nan_error_count <= nan_cnt;
    in_recover_count   <= rec_cnt;
    in_fail_run        <= fails;
    // ready is settled at the falling edge, so the next rising edge takes it
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // drop valid, let every query come back, then let the block go idle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_queries != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(logic [TIME_W-1:0] window, logic [SCORE_W-1:0] ok_at,
                              logic [SCORE_W-1:0] warn_at);
    wait_for_results();
    write_reg(CFG_WINDOW, window);
    write_reg(CFG_OK, CFG_DATA_W'(ok_at));
    write_reg(CFG_WARN, CFG_DATA_W'(warn_at));
    win_cur = window;
  endtask

  // time spread relative to the window, bounded for huge windows
  function automatic logic [TIME_W-1:0] span(int unsigned divisor);
    if (win_cur >= 32'd4000000) return 32'd100000;
    return win_cur / divisor + 32'd1;
  endfunction

  // mostly a coherent spike stream with queries near it, some noise on top
  task automatic random_request(output bit counted);
    int unsigned        pick;
    int unsigned        severity;
    logic [FUNC_W-1:0]  f;
    logic [TIME_W-1:0]  now;
    logic [RMS_W-1:0]   g;
    logic [RMS_W-1:0]   c;
    logic [COUNT_W-1:0] n;
    logic [COUNT_W-1:0] r;
    logic [COUNT_W-1:0] fl;
    pick     = $urandom_range(0, 99);
    severity = $urandom_range(0, 3);
    counted  = 1'b1;
    case (severity)
      0: begin
        g = '0; c = '0; n = '0; r = '0; fl = '0;
      end
      1: begin
        g  = RMS_W'($urandom_range(0, 600));
        c  = RMS_W'($urandom_range(0, 600));
        n  = $urandom_range(0, 5);
        r  = $urandom_range(0, 3);
        fl = $urandom_range(0, 5);
      end
      2: begin
        g  = RMS_W'($urandom_range(0, 2000));
        c  = RMS_W'($urandom_range(0, 2000));
        n  = $urandom_range(0, 24);
        r  = $urandom_range(0, 10);
        fl = $urandom_range(0, 25);
      end
      default: begin
        g  = RMS_W'($urandom_range(0, 65535));
        c  = RMS_W'($urandom_range(0, 65535));
        n  = $urandom;
        r  = $urandom;
        fl = $urandom;
      end
    endcase
    if (pick < 2) begin
      offer(FUNC_CLEAR, $urandom, g, c, n, r, fl);
    end else if (pick < 54) begin
      // dense or sparse spacing so the count spans empty to full ring
      t_now    = t_now + $urandom_range(0, $urandom_range(0, 1) ? span(40) : span(6));
      last_rec = t_now;
      offer(FUNC_RECORD, t_now, g, c, n, r, fl);
    end else if (pick < 88) begin
      case ($urandom_range(0, 5))
        0:       now = last_rec + win_cur;          // newest spike exactly at the edge
        1:       now = last_rec + win_cur + 32'd1;  // newest spike just too old
        default: now = t_now + $urandom_range(0, span(2));
      endcase
      offer(FUNC_QUERY, now, g, c, n, r, fl);
    end else if (pick < 91) begin
      counted = 1'b0;
      offer(FUNC_SPARE, $urandom, g, c, n, r, fl);
    end else begin
      // noise: any code at any time, breaks the ordering of the stream
      f       = FUNC_W'($urandom_range(0, 3));
      counted = (f != FUNC_SPARE);
      offer(f, $urandom, g, c, n, r, fl);
    end
  endtask

  initial begin : stimulus
    int          phase;
    int          done;
    bit          counted;
    int unsigned lv_ok;
    int unsigned lv_warn;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests under reset settings
    offer(FUNC_QUERY, 32'd0, '0, '0, '0, '0, '0);                  // empty ring, full score
    offer(FUNC_QUERY, '1, '1, '1, '1, '1, '1);                     // huge counts saturate
    offer(FUNC_QUERY, 32'd100, '0, '0, 32'd9, '0, '0);             // exactly ok level
    offer(FUNC_QUERY, 32'd100, '0, '0, 32'd19, '0, '0);            // exactly warn level
    offer(FUNC_QUERY, 32'd100, '0, 16'd15, 32'd19, '0, '0);        // one below warn
    offer(FUNC_QUERY, 32'd100, 16'd10, '0, 32'd21, 32'd9, 32'd23); // just past each cap
    offer(FUNC_SPARE, 32'hA5A5_5A5A, '1, '1, '1, '1, '1);          // unused code, no result
    offer(FUNC_RECORD, 32'hFFFF_FFF0, '0, '0, '0, '0, '0);
    offer(FUNC_RECORD, 32'hFFFF_FFFA, '0, '0, '0, '0, '0);
    offer(FUNC_RECORD, 32'd5, '0, '0, '0, '0, '0);
    offer(FUNC_QUERY, 32'd20, '0, '0, '0, '0, '0);                 // ages wrap past zero
    offer(FUNC_QUERY, 32'd10005, '0, '0, '0, '0, '0);              // window edge
    offer(FUNC_RECORD, 32'h8000_0000, '0, '0, '0, '0, '0);
    offer(FUNC_QUERY, 32'd30, '0, '0, '0, '0, '0);                 // stale newest stops walk
    offer(FUNC_CLEAR, '1, '0, '0, '0, '0, '0);
    offer(FUNC_QUERY, 32'd5, '0, '0, '0, '0, '0);

    // zero window, plus a write to the unused register index
    load_setting(32'd0, OK_RST, WARN_RST);
    write_reg(CFG_SPARE, '1);
    offer(FUNC_RECORD, 32'd77, '0, '0, '0, '0, '0);
    offer(FUNC_QUERY, 32'd77, '0, '0, '0, '0, '0);
    offer(FUNC_QUERY, 32'd78, '0, '0, '0, '0, '0);

    // widest window, ok threshold at zero
    load_setting('1, 10'd0, 10'd1023);
    offer(FUNC_QUERY, 32'd0, '1, '0, '0, '0, '0);

    // ok threshold out of reach of a perfect score, warn threshold exactly at it
    load_setting('1, 10'd1023, 10'd1000);
    offer(FUNC_QUERY, 32'd0, '0, '0, '0, '0, '0);

    // random phases, each under its own setting
    for (phase = 0; phase < PHASES; phase++) begin
      t_now = $urandom;
      case (phase)
        0: begin
          load_setting(WINDOW_RST, OK_RST, WARN_RST);
          t_now = 32'hFFFF_0000;
        end
        1: load_setting(32'd0, 10'd1000, 10'd0);
        2: load_setting('1, 10'd0, 10'd1023);
        3: begin
          load_setting(32'd250, 10'd1023, 10'd1000);
          t_now = 32'hFFFF_FF00;
        end
        4: begin
          lv_ok   = $urandom_range(400, 1000);
          lv_warn = $urandom_range(0, lv_ok);
          load_setting($urandom_range(100, 60000), SCORE_W'(lv_ok), SCORE_W'(lv_warn));
        end
        default: load_setting(32'd5000, 10'd700, 10'd900); // warn above ok
      endcase
      last_rec = t_now;
      // a stretch with no idling, and none at all in the last phase
      sender_idle = (phase != 2) && (phase != PHASES - 1);
      sink_stalls = sender_idle;
      done = 0;
      while (done < PHASE_ITEMS) begin
        random_request(counted);
        if (counted) begin
          done++;
          // sender holds back until every result is home
          if (done == PHASE_ITEMS / 2 && (phase == 1 || phase == 4)) wait_for_results();
        end
      end
    end

    wait_for_results();
    if (mismatches == 0 && open_queries == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/swhm_pkg.sv
rtl/swhm_ram.sv
rtl/swhm_ctrl.sv
rtl/swhm_dp.sv
rtl/spike_window_health_monitor.sv
tb/health_score_checker.sv
tb/tb_spike_window_health_monitor.sv
